FILE: rtl/fuzzy_match_scorer_defines.svh
// assertion macros for the fuzzy match scorer
// no dependencies; included by the top level only
`ifndef FUZZY_MATCH_SCORER_DEFINES_SVH
`define FUZZY_MATCH_SCORER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fms_pkg.sv
// shared types, constants and helpers of the fuzzy match scorer
// no dependencies
package fms_pkg;

  localparam int unsigned PAT_STORE_CHARS = 32;
  localparam int unsigned CHAR_IDX_W      = 5;
  localparam int unsigned PAT_LEN_W       = 6;
  localparam int unsigned PAT_WORDS       = 4;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned SCORE_W         = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd4;

  // score weights
  localparam logic [SCORE_W-1:0] SCORE_FULL     = 10'd100;
  localparam logic [SCORE_W-1:0] SCORE_MATCH    = 10'd10;
  localparam logic [SCORE_W-1:0] BONUS_CONSEC   = 10'd5;
  localparam logic [SCORE_W-1:0] BONUS_BOUNDARY = 10'd3;

  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_HYPHEN     = 8'h2D;
  localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_OFFSET     = 8'h20;

  typedef logic [PAT_STORE_CHARS-1:0][7:0] pat_chars_t;

  // one item as handed to the scoring core
  typedef struct packed {
    logic       fire;
    logic       no_char;
    logic       end_of_text;
    logic [7:0] text_char;
  } step_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               too_long;
  } result_t;

  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

FILE: rtl/fms_cfg_regs.sv
// pattern configuration registers with lower-cased pattern view
// depends on fms_pkg
module fms_cfg_regs #(
  parameter int unsigned PATTERN_MAX = 32,
  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fms_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fms_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output fms_pkg::pat_chars_t                 pattern_chars_o,
  output logic [LenW-1:0]                     active_len_o
);

  logic [fms_pkg::PAT_LEN_W-1:0]  len_q, len_d;
  logic [fms_pkg::PAT_WORDS-1:0][fms_pkg::CFG_DATA_W-1:0] word_q, word_d;

  always_comb begin
    len_d  = len_q;
    word_d = word_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        fms_pkg::CFG_PATTERN_LENGTH: len_d = cfg_data_i[fms_pkg::PAT_LEN_W-1:0];
        fms_pkg::CFG_PATTERN_WORD_0: word_d[0] = cfg_data_i;
        fms_pkg::CFG_PATTERN_WORD_1: word_d[1] = cfg_data_i;
        fms_pkg::CFG_PATTERN_WORD_2: word_d[2] = cfg_data_i;
        fms_pkg::CFG_PATTERN_WORD_3: word_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      word_q <= '0;
    end else begin
      len_q  <= len_d;
      word_q <= word_d;
    end
  end

  // lower-case every stored character
  always_comb begin
    for (int i = 0; i < fms_pkg::PAT_STORE_CHARS; i++) begin
      pattern_chars_o[i] = fms_pkg::lower_byte(word_q[i / 8][(i % 8) * 8 +: 8]);
    end
  end

  // length saturates at the pattern capacity
  always_comb begin
    if (7'(len_q) > 7'(PATTERN_MAX)) begin
      active_len_o = LenW'(PATTERN_MAX);
    end else begin
      active_len_o = LenW'(len_q);
    end
  end

endmodule

FILE: rtl/fms_match_core.sv
// per-character scoring: shift-and substring check and greedy subsequence score
// depends on fms_pkg
module fms_match_core #(
  parameter int unsigned PATTERN_MAX  = 32,
  parameter int unsigned MAX_TEXT_LEN = 4096,
  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fms_pkg::step_t      step_i,
  input  fms_pkg::pat_chars_t pattern_chars_i,
  input  logic [LenW-1:0]     active_len_i,
  output fms_pkg::result_t    result_o
);

  localparam int unsigned TpW = $clog2(MAX_TEXT_LEN + 1);

  logic [PATTERN_MAX-1:0]     prefix_q, prefix_d;
  logic                       sub_q, sub_d;
  logic [LenW-1:0]            pos_q, pos_d;
  logic [fms_pkg::SCORE_W-1:0] run_q, run_d;
  logic                       consec_q, consec_d;
  logic [TpW-1:0]             last_q, last_d;
  logic [7:0]                 prev_q, prev_d;
  logic [TpW-1:0]             tp_q, tp_d;
  logic                       exceed_q, exceed_d;

  logic [7:0]                 c;
  logic [PATTERN_MAX-1:0]     eq, used, top_sel;
  logic [7:0]                 pos_char;
  logic                       boundary, consec_ok;
  logic [fms_pkg::SCORE_W-1:0] add;

  assign c = fms_pkg::lower_byte(step_i.text_char);

  // characters beyond the stored pattern read as byte zero
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_lane
    if (j < fms_pkg::PAT_STORE_CHARS) begin : g_stored
      assign eq[j] = (pattern_chars_i[j] == c);
    end else begin : g_zero
      assign eq[j] = (c == 8'h00);
    end
    assign used[j]    = (7'(j) < 7'(active_len_i));
    assign top_sel[j] = (7'(j + 1) == 7'(active_len_i));
  end

  always_comb begin
    if (32'(pos_q) < 32'(fms_pkg::PAT_STORE_CHARS)) begin
      pos_char = pattern_chars_i[fms_pkg::CHAR_IDX_W'(pos_q)];
    end else begin
      pos_char = 8'h00;
    end
  end

  assign boundary  = (tp_q == '0) || (prev_q == fms_pkg::CHAR_SPACE) ||
                     (prev_q == fms_pkg::CHAR_UNDERSCORE) ||
                     (prev_q == fms_pkg::CHAR_HYPHEN);
  assign consec_ok = consec_q &&
                     ((TpW + 1)'(tp_q) == (TpW + 1)'(last_q) + (TpW + 1)'(1));
  assign add = fms_pkg::SCORE_MATCH +
               (consec_ok ? fms_pkg::BONUS_CONSEC : '0) +
               (boundary ? fms_pkg::BONUS_BOUNDARY : '0);

  always_comb begin
    prefix_d = prefix_q;
    sub_d    = sub_q;
    pos_d    = pos_q;
    run_d    = run_q;
    consec_d = consec_q;
    last_d   = last_q;
    prev_d   = prev_q;
    tp_d     = tp_q;
    exceed_d = exceed_q;

    if (step_i.fire && !step_i.no_char) begin
      if (tp_q >= TpW'(MAX_TEXT_LEN)) begin
        exceed_d = 1'b1;
      end else begin
        if (active_len_i != '0) begin
          prefix_d = ((prefix_q << 1) | PATTERN_MAX'(1)) & eq & used;
          if (|(prefix_d & top_sel)) begin
            sub_d = 1'b1;
          end
          if (pos_q < active_len_i && c == pos_char) begin
            run_d = run_q + add;
            if (!consec_ok) begin
              consec_d = 1'b0;
            end
            last_d = tp_q;
            pos_d  = pos_q + LenW'(1);
          end
        end
        prev_d = c;
        tp_d   = tp_q + TpW'(1);
      end
    end

    // result from the updated state
    result_o.too_long = exceed_d;
    if (exceed_d) begin
      result_o.score = '0;
    end else if (active_len_i == '0 || sub_d) begin
      result_o.score = fms_pkg::SCORE_FULL;
    end else if (pos_d == active_len_i) begin
      result_o.score = run_d;
    end else begin
      result_o.score = '0;
    end

    // end of text: back to the per-text start values
    if (step_i.fire && step_i.end_of_text) begin
      prefix_d = '0;
      sub_d    = 1'b0;
      pos_d    = '0;
      run_d    = '0;
      consec_d = 1'b1;
      last_d   = '0;
      prev_d   = '0;
      tp_d     = '0;
      exceed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      sub_q    <= 1'b0;
      pos_q    <= '0;
      run_q    <= '0;
      consec_q <= 1'b1;
      last_q   <= '0;
      prev_q   <= '0;
      tp_q     <= '0;
      exceed_q <= 1'b0;
    end else begin
      prefix_q <= prefix_d;
      sub_q    <= sub_d;
      pos_q    <= pos_d;
      run_q    <= run_d;
      consec_q <= consec_d;
      last_q   <= last_d;
      prev_q   <= prev_d;
      tp_q     <= tp_d;
      exceed_q <= exceed_d;
    end
  end

endmodule

FILE: rtl/fuzzy_match_scorer.sv
// fuzzy match scorer top level: input register, scoring core, result register
// depends on fms_pkg, fms_cfg_regs, fms_match_core and fuzzy_match_scorer_defines.svh
//
// Scores a text, streamed one byte per beat, against a pattern of up to 32
// characters held in the configuration registers (length at index 0, four
// 64-bit words of characters at indexes 1 to 4, character 0 in the low
// byte). Matching is case-insensitive for ASCII letters. A beat with
// no_char_i set carries no character; a beat with end_of_text_i set closes
// the text and is the only beat that produces a result: 100 for an empty
// pattern or a contiguous hit, otherwise the greedy subsequence score
// (10 per matched character, +5 while matches stay consecutive, +3 at text
// start or after space, underscore or hyphen), or 0 if not every pattern
// character was matched. Texts longer than MAX_TEXT_LEN characters report
// too_long_o with a score of 0. Throughput is one beat per clock while the
// input does not stall: the per-character state update (shift-and prefix
// vector plus score adder) is one combinational update of the core's state
// registers. A closing beat passes through the input register and is then
// scored into the result register, which drives the output. The input
// stalls only when a closing beat sits in the input register and the
// previous result is still held by a stalled output. Write configuration
// only while idle.
`include "fuzzy_match_scorer_defines.svh"

module fuzzy_match_scorer #(
  parameter int unsigned PATTERN_MAX  = 32,
  parameter int unsigned MAX_TEXT_LEN = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [fms_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fms_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // text beats in
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        text_char_i,
  input  logic                              no_char_i,
  input  logic                              end_of_text_i,
  // results out
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fms_pkg::SCORE_W-1:0]       score_o,
  output logic                              too_long_o
);

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] char_q;
  logic       no_char_q;
  logic       end_q;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic [fms_pkg::SCORE_W-1:0] score_q;
  logic                        too_long_q;

  logic                 in_accept;
  logic                 out_free;
  logic                 fire;
  fms_pkg::step_t       step;
  fms_pkg::result_t     result;
  fms_pkg::pat_chars_t  pattern_chars;
  logic [LenW-1:0]      active_len;

  // a beat that closes no text never needs the result register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && (out_free || !end_q);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && end_q) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q    <= text_char_i;
      no_char_q <= no_char_i;
      end_q     <= end_of_text_i;
    end
    if (fire && end_q) begin
      score_q    <= result.score;
      too_long_q <= result.too_long;
    end
  end

  assign step.fire        = fire;
  assign step.no_char     = no_char_q;
  assign step.end_of_text = end_q;
  assign step.text_char   = char_q;

  fms_cfg_regs #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cfg_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pattern_chars_o (pattern_chars),
    .active_len_o    (active_len)
  );

  fms_match_core #(
    .PATTERN_MAX  (PATTERN_MAX),
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_match_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .pattern_chars_i (pattern_chars),
    .active_len_i    (active_len),
    .result_o        (result)
  );

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;
  assign too_long_o  = too_long_q;

  // a closing beat always lands in the result register
  `FMS_ASSERT_NEXT(a_close_gives_result, clk_i, rst_ni, fire && end_q, out_valid_q,
                   "closing beat produced no result")

  // the input only stalls behind a blocked result
  `FMS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_valid_q && !fire,
                  end_q && out_valid_q && out_stall_i,
                  "input stalled without a blocked result")

  // an overlong text never carries a score
  `FMS_ASSERT_NOW(a_too_long_zero, clk_i, rst_ni, out_valid_q && too_long_q,
                  score_q == '0, "too_long result with non-zero score")

endmodule

FILE: verif/tb_fuzzy_match_scorer.sv
// self-checking bench for the fuzzy match scorer: directed texts, random pattern phases
// and texts past the length limit, every result checked against an in-bench score predictor
// depends on fms_pkg and the fuzzy_match_scorer rtl
module tb_fuzzy_match_scorer;

  localparam int unsigned TEXT_LIMIT   = 4096;
  localparam int unsigned PAT_LIMIT    = 32;
  localparam int unsigned RANDOM_BEATS = 1250;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES  = 300;

  localparam logic [fms_pkg::CFG_IDX_W-1:0] WORD_REGS [fms_pkg::PAT_WORDS] = '{
    fms_pkg::CFG_PATTERN_WORD_0, fms_pkg::CFG_PATTERN_WORD_1,
    fms_pkg::CFG_PATTERN_WORD_2, fms_pkg::CFG_PATTERN_WORD_3
  };

  // one beat of text as the sender offers it
  typedef struct packed {
    logic [7:0] ch;
    logic       no_char;
    logic       eot;
  } text_beat_t;

  // shapes of random text relative to the current pattern
  typedef enum int unsigned {
    TXT_SUBSTRING,
    TXT_SUBSEQUENCE,
    TXT_PARTIAL,
    TXT_NOISE,
    TXT_EMPTY
  } text_kind_e;

  // dut ports
  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [fms_pkg::CFG_IDX_W-1:0]  cfg_index_i   = fms_pkg::CFG_PATTERN_LENGTH;
  logic [fms_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic [7:0]                     text_char_i   = '0;
  logic                           no_char_i     = 1'b0;
  logic                           end_of_text_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic [fms_pkg::SCORE_W-1:0]    score_o;
  logic                           too_long_o;

  // bench copy of the configuration registers
  logic [fms_pkg::PAT_LEN_W-1:0] cfg_len = '0;
  logic [63:0]                   cfg_word [fms_pkg::PAT_WORDS] = '{default: '0};

  // per-text scoring state of the predictor
  logic [31:0]                 prefix_vec;
  bit                          substr_hit;
  int unsigned                 pat_pos;
  logic [fms_pkg::SCORE_W-1:0] run_score;
  bit                          in_run;
  int unsigned                 last_hit_pos;
  logic [7:0]                  prev_c;
  int unsigned                 txt_pos;
  bit                          overlong;

  // stimulus side
  text_beat_t       text_beats [$];
  fms_pkg::result_t expected_scores [$];
  logic [7:0]       pat_chars [fms_pkg::PAT_STORE_CHARS];
  int unsigned pat_active      = 0;
  int unsigned beats_queued    = 0;
  int unsigned beats_accepted  = 0;
  int unsigned mismatches      = 0;
  int unsigned hold_requests   = 0;
  bit          sender_gaps_on  = 1'b1;
  bit          receiver_stalls_on = 1'b1;

  // driver and monitor locals
  int unsigned      gap_left;
  text_beat_t       next_beat;
  int unsigned      stall_left;
  int unsigned      hold_left;
  int unsigned      holds_taken;
  fms_pkg::result_t want;

  fuzzy_match_scorer #(
    .PATTERN_MAX (PAT_LIMIT),
    .MAX_TEXT_LEN(TEXT_LIMIT)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_char_i  (text_char_i),
    .no_char_i    (no_char_i),
    .end_of_text_i(end_of_text_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .score_o      (score_o),
    .too_long_o   (too_long_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // score predictor
  // ------------------------------------------------------------------

  // ascii-only lower-casing, everything outside A..Z passes through
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= fms_pkg::CHAR_UPPER_A && c <= fms_pkg::CHAR_UPPER_Z) begin
      return c + fms_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [7:0] pattern_char(input int unsigned j);
    return fold_case(cfg_word[j / 8][(j % 8) * 8 +: 8]);
  endfunction

  // a length above the store size saturates at the store size
  function automatic int unsigned active_chars();
    return (cfg_len > PAT_LIMIT) ? PAT_LIMIT : int'(cfg_len);
  endfunction

  function automatic void clear_text();
    prefix_vec   = '0;
    substr_hit   = 1'b0;
    pat_pos      = 0;
    run_score    = '0;
    in_run       = 1'b1;
    last_hit_pos = 0;
    prev_c       = '0;
    txt_pos      = 0;
    overlong     = 1'b0;
  endfunction

  // advances the text state by one accepted beat, queues the score on a closing beat
  function automatic void score_beat(input text_beat_t b);
    logic [7:0]       c;
    logic [31:0]      eq;
    logic [32:0]      span;
    int unsigned      m;
    int unsigned      j;
    fms_pkg::result_t res;
    m = active_chars();
    c = fold_case(b.ch);
    if (!b.no_char) begin
      if (txt_pos >= TEXT_LIMIT) begin
        // past the limit: flag only, position stays put
        overlong = 1'b1;
      end else begin
        if (m > 0) begin
          // shift-and prefix vector for the contiguous hit
          eq = '0;
          for (j = 0; j < m; j++) begin
            if (pattern_char(j) == c) begin
              eq[j] = 1'b1;
            end
          end
          span = (33'd1 << m) - 33'd1;
          prefix_vec = ((prefix_vec << 1) | 32'd1) & eq & span[31:0];
          if (prefix_vec[m-1]) begin
            substr_hit = 1'b1;
          end
          // greedy subsequence scoring
          if (pat_pos < m && c == pattern_char(pat_pos)) begin
            run_score = run_score + fms_pkg::SCORE_MATCH;
            if (in_run && txt_pos == last_hit_pos + 1) begin
              run_score = run_score + fms_pkg::BONUS_CONSEC;
            end else begin
              in_run = 1'b0;
            end
            if (txt_pos == 0 || prev_c == fms_pkg::CHAR_SPACE ||
                prev_c == fms_pkg::CHAR_UNDERSCORE || prev_c == fms_pkg::CHAR_HYPHEN) begin
              run_score = run_score + fms_pkg::BONUS_BOUNDARY;
            end
            last_hit_pos = txt_pos;
            pat_pos++;
          end
        end
        prev_c = c;
        txt_pos++;
      end
    end
    if (b.eot) begin
      res.too_long = overlong;
      if (overlong) begin
        res.score = '0;
      end else if (m == 0 || substr_hit) begin
        res.score = fms_pkg::SCORE_FULL;
      end else if (pat_pos == m) begin
        res.score = run_score;
      end else begin
        res.score = '0;
      end
      expected_scores.insert(expected_scores.size(), res);
      clear_text();
    end
  endfunction

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ($urandom_range(0, 1) == 0) begin
      return c;
    end
    if (c >= "a" && c <= "z") begin
      return c - fms_pkg::CASE_OFFSET;
    end
    if (c >= fms_pkg::CHAR_UPPER_A && c <= fms_pkg::CHAR_UPPER_Z) begin
      return c + fms_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(0, 2))
      0: return fms_pkg::CHAR_SPACE;
      1: return fms_pkg::CHAR_UNDERSCORE;
      default: return fms_pkg::CHAR_HYPHEN;
    endcase
  endfunction

  // text padding: small alphabet that overlaps the patterns, separators, raw bytes
  function automatic logic [7:0] filler_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return flip_case("a" + 8'($urandom_range(0, 7)));
    end
    if (r < 75) begin
      return pick_separator();
    end
    return 8'($urandom);
  endfunction

  function automatic void push_beat(input logic [7:0] ch, input bit nochar, input bit eot);
    text_beats.insert(text_beats.size(), text_beat_t'{ch, nochar, eot});
    beats_queued++;
  endfunction

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      push_beat(s[i], 1'b0, i == s.len() - 1);
    end
  endfunction

  // pattern characters from a string, unused slots filled with junk
  function automatic void load_chars(input string s);
    int i;
    for (i = 0; i < fms_pkg::PAT_STORE_CHARS; i++) begin
      pat_chars[i] = (i < s.len()) ? s[i] : 8'($urandom);
    end
  endfunction

  function automatic int unsigned pick_pattern();
    int unsigned r;
    int unsigned i;
    for (i = 0; i < fms_pkg::PAT_STORE_CHARS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        pat_chars[i] = flip_case("a" + 8'($urandom_range(0, 4)));
      end else if (r < 92) begin
        pat_chars[i] = pick_separator();
      end else begin
        pat_chars[i] = 8'($urandom);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return 0;
    end
    if (r < 58) begin
      return $urandom_range(1, 6);
    end
    if (r < 78) begin
      return $urandom_range(7, 16);
    end
    if (r < 90) begin
      return PAT_LIMIT;
    end
    return $urandom_range(PAT_LIMIT + 1, 63);
  endfunction

  function automatic text_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      return TXT_SUBSTRING;
    end
    if (r < 60) begin
      return TXT_SUBSEQUENCE;
    end
    if (r < 75) begin
      return TXT_PARTIAL;
    end
    if (r < 90) begin
      return TXT_NOISE;
    end
    return TXT_EMPTY;
  endfunction

  // queues one text built around the current pattern, returns the beats that count
  function automatic int unsigned queue_text(input text_kind_e kind);
    logic [7:0]  chars [$];
    int unsigned m;
    int unsigned keep;
    int unsigned i;
    bit          close_apart;
    m = pat_active;
    case (kind) inside
      TXT_SUBSTRING: begin
        repeat ($urandom_range(0, 3)) chars.insert(chars.size(), filler_char());
        for (i = 0; i < m; i++) begin
          chars.insert(chars.size(), flip_case(pat_chars[i]));
        end
        repeat ($urandom_range(0, 3)) chars.insert(chars.size(), filler_char());
      end
      TXT_SUBSEQUENCE, TXT_PARTIAL: begin
        keep = (kind == TXT_PARTIAL && m > 0) ? $urandom_range(0, m - 1) : m;
        for (i = 0; i < keep; i++) begin
          repeat ($urandom_range(0, 2)) chars.insert(chars.size(), filler_char());
          chars.insert(chars.size(), flip_case(pat_chars[i]));
        end
        repeat ($urandom_range(0, 2)) chars.insert(chars.size(), filler_char());
      end
      TXT_NOISE: begin
        repeat ($urandom_range(1, 12)) chars.insert(chars.size(), filler_char());
      end
      default: begin
      end
    endcase
    close_apart = ($urandom_range(0, 4) == 0) || (chars.size() == 0);
    for (i = 0; i < chars.size(); i++) begin
      // now and then a dropped beat with no character
      if ($urandom_range(0, 19) == 0) begin
        push_beat(8'($urandom), 1'b1, 1'b0);
      end
      push_beat(chars[i], 1'b0, (i == chars.size() - 1) && !close_apart);
    end
    if (close_apart) begin
      push_beat(8'($urandom), 1'b1, 1'b1);
    end
    return chars.size() + (close_apart ? 1 : 0);
  endfunction

  // long text of n characters from a..h, pattern-ish tail
  function automatic void queue_long_text(input int unsigned n, input bit close_apart);
    int unsigned i;
    for (i = 0; i < n - 4; i++) begin
      push_beat(flip_case("a" + 8'($urandom_range(0, 7))), 1'b0, 1'b0);
    end
    push_beat("q", 1'b0, 1'b0);
    push_beat(fms_pkg::CHAR_UNDERSCORE, 1'b0, 1'b0);
    push_beat(fms_pkg::CHAR_HYPHEN, 1'b0, 1'b0);
    push_beat("Z", 1'b0, !close_apart);
    if (close_apart) begin
      push_beat(8'h00, 1'b1, 1'b1);
    end
  endfunction

  // writes length and all four pattern words back to back, only while idle
  task automatic program_pattern(input int unsigned len, input bit garble);
    logic [63:0] w;
    int unsigned k;
    int unsigned b;
    w = {$urandom, $urandom};
    if (!garble) begin
      w = '0;
    end
    w[fms_pkg::PAT_LEN_W-1:0] = len[fms_pkg::PAT_LEN_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= fms_pkg::CFG_PATTERN_LENGTH;
    cfg_data_i  <= w;
    cfg_len      = len[fms_pkg::PAT_LEN_W-1:0];
    for (k = 0; k < fms_pkg::PAT_WORDS; k++) begin
      for (b = 0; b < 8; b++) begin
        w[b*8 +: 8] = pat_chars[k*8 + b];
      end
      @(posedge clk_i);
      cfg_index_i <= WORD_REGS[k];
      cfg_data_i  <= w;
      cfg_word[k]  = w;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pat_active = (len > PAT_LIMIT) ? PAT_LIMIT : len;
    @(negedge clk_i);
  endtask

  // every queued beat taken, every score back, then a further drain wait
  task automatic wait_idle();
    do @(negedge clk_i);
    while (beats_accepted != beats_queued || expected_scores.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // ------------------------------------------------------------------
  // sender: offers one beat at a time, holds it steady while stalled
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      text_char_i   <= '0;
      no_char_i     <= 1'b0;
      end_of_text_i <= 1'b0;
      gap_left       = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        score_beat(text_beat_t'{text_char_i, no_char_i, end_of_text_i});
        beats_accepted <= beats_accepted + 1;
      end
      // line is free when idle or when the beat just went in
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (text_beats.size() != 0) begin
          next_beat      = text_beats.pop_front();
          in_valid_i    <= 1'b1;
          text_char_i   <= next_beat.ch;
          no_char_i     <= next_beat.no_char;
          end_of_text_i <= next_beat.eot;
          gap_left       = sender_gaps_on ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // receiver: checks each result beat, stalls at random, long hold on request
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left   = 0;
      hold_left    = 0;
      holds_taken  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_scores.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual score %0d too_long %0b",
                   $time, score_o, too_long_o);
          mismatches++;
        end else begin
          want = expected_scores.pop_front();
          if (score_o !== want.score) begin
            $display("%0t: score mismatch: expected %0d, actual %0d",
                     $time, want.score, score_o);
            mismatches++;
          end
          if (too_long_o !== want.too_long) begin
            $display("%0t: too_long mismatch: expected %0b, actual %0b",
                     $time, want.too_long, too_long_o);
            mismatches++;
          end
        end
      end
      // long hold so the block backs up and stalls its input
      if (holds_taken != hold_requests) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (receiver_stalls_on) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus and verdict
  // ------------------------------------------------------------------
  initial begin
    int unsigned random_count;
    int unsigned phase_count;
    int unsigned budget;
    int unsigned phase;
    int unsigned len;
    random_count = 0;
    phase = 0;
    clear_text();
    load_chars("");
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset pattern is empty: any text scores full marks
    push_beat(8'hFF, 1'b0, 1'b1);
    push_beat(8'hAA, 1'b1, 1'b0);      // no character and no end: dropped
    push_beat(8'h55, 1'b1, 1'b1);      // empty text
    wait_idle();

    load_chars("Ab");
    program_pattern(2, 1'b0);
    push_beat(8'h00, 1'b1, 1'b1);      // empty text against a real pattern
    push_text("aB");                   // contiguous hit, case folded both sides
    push_text("a-b");                  // first hit at text start ends the run, hyphen bonus
    push_text("xaxb");                 // first hit at position one keeps the run
    // byte extremes around the matches, space boundary before the last one
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat("A", 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(fms_pkg::CHAR_SPACE, 1'b0, 1'b0);
    push_beat("b", 1'b0, 1'b1);
    // text left open across a register write
    push_beat("a", 1'b0, 1'b0);
    wait_idle();
    load_chars("AX");
    program_pattern(2, 1'b0);
    push_beat("x", 1'b0, 1'b1);
    wait_idle();

    // length above the store size, junk in the upper data bits
    load_chars("abcdefghijklmnopqrstuvwxyz012345");
    program_pattern(40, 1'b1);
    push_text("ABC");

    // random phases: new pattern each time, idle before every write
    while (random_count < RANDOM_BEATS) begin
      wait_idle();
      phase++;
      len = pick_pattern();
      program_pattern(len, $urandom_range(0, 3) == 0);
      sender_gaps_on     = ($urandom_range(0, 4) != 0);
      receiver_stalls_on = ($urandom_range(0, 4) != 0);
      if (phase == 2) begin
        // a stretch with no idling on either side
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
      end
      if (phase == 1 || $urandom_range(0, 7) == 0) begin
        // sender keeps streaming while the receiver sits on a result
        sender_gaps_on = 1'b0;
        hold_requests++;
      end
      budget = $urandom_range(60, 200);
      phase_count = 0;
      while (phase_count < budget) begin
        phase_count += queue_text(pick_kind());
      end
      random_count += phase_count;
    end

    // length limit: exactly at it, one past it, and well past it closed by an empty beat
    wait_idle();
    load_chars("q-z");
    program_pattern(3, 1'b0);
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b1;
    queue_long_text(TEXT_LIMIT, 1'b0);
    queue_long_text(TEXT_LIMIT + 1, 1'b0);
    queue_long_text(TEXT_LIMIT + 4, 1'b1);

    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/fms_pkg.sv
rtl/fms_cfg_regs.sv
rtl/fms_match_core.sv
rtl/fuzzy_match_scorer.sv
verif/tb_fuzzy_match_scorer.sv
